// ===== sv/itl_pkg.sv =====
// Package for the interval table lookup block.
// Holds table sizing, status and width-mode codes, and the item and RAM request types.
// No dependencies; every other file imports it.
`default_nettype none

package itl_pkg;

    // Table sizing.
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Fixed field widths.
    localparam int KEY_W   = 32;
    localparam int ENTRY_W = 8;
    localparam int STAT_W  = 2;
    localparam int MODE_W  = 2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERR  = 2'd2;

    // Key width modes.
    localparam logic [MODE_W-1:0] MODE_16 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_32 = 2'd2;

    // Operation codes.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Key mask in sixteen-bit mode.
    localparam logic [KEY_W-1:0] MASK_16 = 32'h0000_FFFF;

    // One input item.
    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key_low;
        logic [KEY_W-1:0] key_high;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ENTRY_W-1:0] entry_index;
        logic [KEY_W-1:0]   range_low;
        logic [KEY_W-1:0]   range_high;
    } out_item_t;

    // One stored interval.
    typedef struct packed {
        logic [KEY_W-1:0] high;
        logic [KEY_W-1:0] low;
    } bound_pair_t;

    // Access request from the sequencer to the bound memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        bound_pair_t      wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

// ===== sv/interval_table_lookup.sv =====
// Top level of the interval table lookup block.
// Holds the key width mode register and ties the sequencer to the bound memory.
// Depends on itl_pkg, itl_bound_ram and itl_search_ctrl.
//
//   Channel   Ports                     Handshake
//   input     start, busy, cmd          item taken when start is high and busy is low
//   result    done, result              one-cycle strobe, receiver cannot stall
//   config    cfg_we, cfg_data          written when cfg_we is high
//
// An insert or an item under an illegal width mode gives its registered result in the
// cycle after it is taken. A lookup runs a search state, which issues a memory read at
// the window midpoint, and a compare state for each binary-search step; it ends in the
// search state on a miss or in the compare state on a hit.
// The block takes a new item in the cycle its previous result is shown.
// Reset empties the table and sets 32-bit keys; the memory itself is not cleared.
`default_nettype none

module interval_table_lookup (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire itl_pkg::in_item_t           cmd,
    output logic                             busy,
    output logic                             done,
    output itl_pkg::out_item_t               result,
    input  wire logic                        cfg_we,
    input  wire logic [itl_pkg::MODE_W-1:0]  cfg_data
);
    import itl_pkg::*;

    logic [MODE_W-1:0] mode_reg, mode_next;
    ram_req_t          ram_req;
    bound_pair_t       ram_rdata;

    // Key width mode register.
    always_comb
    begin
        mode_next = cfg_we ? cfg_data : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_32;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Search and insert sequencer.
    itl_search_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .mode      (mode_reg),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Interval bound storage.
    itl_bound_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== sv/itl_bound_ram.sv =====
// Bound memory: one write port and one registered read port.
// Each word holds the low and high bound of one stored interval.
// Depends on itl_pkg.
`default_nettype none

module itl_bound_ram (
    input  wire logic                 clk,
    input  wire itl_pkg::ram_req_t    req,
    output itl_pkg::bound_pair_t      rdata
);
    import itl_pkg::*;

    bound_pair_t mem [TABLE_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/itl_search_ctrl.sv =====
// Sequencer for inserts and binary-search lookups over the bound memory.
// Keeps the entry count and the last stored high bound, and registers each result.
// Depends on itl_pkg.
`default_nettype none

module itl_search_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire itl_pkg::in_item_t           cmd,
    input  wire logic [itl_pkg::MODE_W-1:0]  mode,
    output logic                             busy,
    output logic                             done,
    output itl_pkg::out_item_t               result,
    output itl_pkg::ram_req_t                ram_req,
    input  wire itl_pkg::bound_pair_t        ram_rdata
);
    import itl_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_CMP    = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0] last_high_reg, last_high_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             wide16_reg, wide16_next;
    logic             done_reg, done_next;
    out_item_t        result_reg, result_next;

    logic             mode_ok;
    logic             mode16;
    logic [KEY_W-1:0] in_mask;
    logic [KEY_W-1:0] klo;
    logic [KEY_W-1:0] khi;
    logic             ins_bad;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid_calc;
    logic [KEY_W-1:0] cmp_mask;
    logic [KEY_W-1:0] b0;
    logic [KEY_W-1:0] b1;

    // Decode the width mode, mask the incoming keys and check whether an insert is refused.
    always_comb
    begin
        mode_ok = (mode == MODE_16) || (mode == MODE_32);
        mode16  = (mode == MODE_16);
        in_mask = mode16 ? MASK_16 : {KEY_W{1'b1}};
        klo     = cmd.key_low & in_mask;
        khi     = cmd.key_high & in_mask;
        ins_bad = (klo > khi)
                || ((count_reg != '0) && ((last_high_reg & in_mask) >= klo))
                || (count_reg == CNT_W'(TABLE_DEPTH));
    end

    // Midpoint of the current search window and the masked bounds read back.
    always_comb
    begin
        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid_calc = mid_sum[CNT_W:1];
        cmp_mask = wide16_reg ? MASK_16 : {KEY_W{1'b1}};
        b0       = ram_rdata.low & cmp_mask;
        b1       = ram_rdata.high & cmp_mask;
    end

    // Next-state logic for the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_high_next = last_high_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        wide16_next    = wide16_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        ram_req        = '0;
        ram_req.waddr  = count_reg[IDX_W-1:0];
        ram_req.wdata  = '{high: khi, low: klo};
        ram_req.raddr  = mid_calc[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    result_next = '{status: ST_ERR, entry_index: '0,
                                    range_low: '0, range_high: '0};
                    if (!mode_ok)
                    begin
                        done_next = 1'b1;
                    end
                    else if (cmd.op == OP_INSERT)
                    begin
                        done_next = 1'b1;
                        if (!ins_bad)
                        begin
                            ram_req.we         = 1'b1;
                            count_next         = count_reg + 1'b1;
                            last_high_next     = khi;
                            result_next.status = ST_OK;
                        end
                    end
                    else
                    begin
                        key_next    = klo;
                        wide16_next = mode16;
                        lo_next     = '0;
                        hi_next     = count_reg;
                        state_next  = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (lo_reg >= hi_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_MISS, entry_index: '0,
                                    range_low: '0, range_high: '0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_req.re = 1'b1;
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (key_reg < b0)
                begin
                    hi_next    = mid_reg;
                    state_next = S_SEARCH;
                end
                else if (key_reg > b1)
                begin
                    lo_next    = mid_reg + 1'b1;
                    state_next = S_SEARCH;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_OK, entry_index: ENTRY_W'(mid_reg),
                                    range_low: b0, range_high: b1};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        last_high_reg <= last_high_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        wide16_reg    <= wide16_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for interval_table_lookup: a directed table, then random phases.
// Expected results come from the directed table where a row gives one, else from a behavioral copy of the table.
// Depends on itl_pkg and the interval_table_lookup RTL.
`timescale 1ns / 1ps

module tb_top;
    import itl_pkg::*;

    // Illegal key width modes; the package names only the two legal ones.
    localparam logic [MODE_W-1:0] MODE_BAD_LO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BAD_HI = 2'd3;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int SETTLE_CYCLES  = 24;
    localparam int END_CYCLES     = 40;
    localparam int DIRECTED_N     = 25;

    localparam logic TYPED   = 1'b1;
    localparam logic UNTYPED = 1'b0;

    // Results that carry nothing but a status.
    localparam out_item_t R_OK   = {ST_OK, 8'd0, 32'd0, 32'd0};
    localparam out_item_t R_MISS = {ST_MISS, 8'd0, 32'd0, 32'd0};
    localparam out_item_t R_ERR  = {ST_ERR, 8'd0, 32'd0, 32'd0};
    localparam out_item_t R_NONE = '0;

    // One row of the directed table: the width mode it runs under, the item, and,
    // where it is plain to see, the result it must give.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        in_item_t          item;
        logic              typed;
        out_item_t         want;
    } directed_row_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    in_item_t          cmd      = '0;
    logic              cfg_we   = 1'b0;
    logic [MODE_W-1:0] cfg_data = MODE_32;
    logic              busy;
    logic              done;
    out_item_t         result;

    // Behavioral copy of the table and the width mode register.
    logic [KEY_W-1:0]  table_lo [TABLE_DEPTH];
    logic [KEY_W-1:0]  table_hi [TABLE_DEPTH];
    int                table_used;
    logic [MODE_W-1:0] mode_now;

    out_item_t         expected_results [$];
    directed_row_t     directed_rows [DIRECTED_N];

    int burst_left;
    int quiet_cycles    = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int n_items         = 0;
    int n_stored        = 0;
    int n_hits          = 0;
    int n_misses        = 0;
    int n_errors        = 0;

    interval_table_lookup u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Applies one item to the table copy and returns the result it must give.
    function automatic out_item_t step_interval_table(in_item_t it);
        out_item_t        r;
        logic [KEY_W-1:0] mask;
        logic [KEY_W-1:0] klo;
        logic [KEY_W-1:0] khi;
        logic [KEY_W-1:0] b0;
        logic [KEY_W-1:0] b1;
        logic             refused;
        int               lo;
        int               hi;
        int               mid;
        r = R_ERR;
        if (mode_now != MODE_16 && mode_now != MODE_32)
            return r;
        mask = (mode_now == MODE_16) ? MASK_16 : '1;
        klo  = it.key_low & mask;
        khi  = it.key_high & mask;
        if (it.op == OP_INSERT)
        begin
            refused = (klo > khi) || (table_used >= TABLE_DEPTH);
            if (table_used > 0)
            begin
                if ((table_hi[table_used - 1] & mask) >= klo)
                    refused = 1'b1;
            end
            if (!refused)
            begin
                table_lo[table_used] = klo;
                table_hi[table_used] = khi;
                table_used++;
                r = R_OK;
            end
            return r;
        end
        // Binary search over the stored intervals, compared at the current width.
        lo = 0;
        hi = table_used;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            b0  = table_lo[mid] & mask;
            b1  = table_hi[mid] & mask;
            if (klo < b0)
                hi = mid;
            else if (klo > b1)
                lo = mid + 1;
            else
            begin
                r.status      = ST_OK;
                r.entry_index = mid[ENTRY_W-1:0];
                r.range_low   = b0;
                r.range_high  = b1;
                return r;
            end
        end
        return R_MISS;
    endfunction

    // Draws one item, mostly shaped by what the table holds so far.
    function automatic in_item_t make_random_item(int insert_pct);
        in_item_t         it;
        logic [KEY_W-1:0] mask;
        logic [KEY_W-1:0] b0;
        logic [KEY_W-1:0] b1;
        logic [KEY_W-1:0] v;
        logic [63:0]      top;
        logic [63:0]      last;
        logic [63:0]      stride;
        logic [63:0]      klo_w;
        logic [63:0]      khi_w;
        logic [63:0]      off;
        int               pick;
        int               idx;
        mask = (mode_now == MODE_16) ? MASK_16 : '1;
        top  = {32'd0, mask};
        last = 64'd0;
        if (table_used > 0)
            last = {32'd0, table_hi[table_used - 1] & mask};
        it.op       = OP_LOOKUP;
        it.key_low  = $urandom;
        it.key_high = $urandom;
        pick        = $urandom_range(0, 99);
        if (pick < insert_pct && last < top)
        begin
            // Well-formed insert after the last interval, sized so the rest of the
            // table still fits below the top key.
            stride      = (top - last) / (TABLE_DEPTH - table_used + 1);
            klo_w       = last + 1 + $urandom_range(0, stride / 2);
            khi_w       = klo_w + $urandom_range(0, stride / 2);
            it.op       = OP_INSERT;
            it.key_low  = (it.key_low & ~mask) | klo_w[KEY_W-1:0];
            it.key_high = (it.key_high & ~mask) | khi_w[KEY_W-1:0];
        end
        else if (pick < insert_pct + 10)
        begin
            // Insert whose low bound does not clear the last stored high bound.
            off = $urandom_range(0, 50);
            if (off > last)
                off = last;
            it.op      = OP_INSERT;
            it.key_low = (it.key_low & ~mask) | (last[KEY_W-1:0] - off[KEY_W-1:0]);
        end
        else if (pick < 80 && table_used > 0)
        begin
            // Lookup on the edges of, inside, or just outside a stored interval.
            idx = $urandom_range(0, table_used - 1);
            b0  = table_lo[idx] & mask;
            b1  = table_hi[idx] & mask;
            case ($urandom_range(0, 4))
                0: v = b0;
                1: v = b1;
                2: v = b0 + $urandom_range(0, b1 - b0);
                3: v = b0 - 1;
                default: v = b1 + 1;
            endcase
            it.key_low = (it.key_low & ~mask) | (v & mask);
        end
        else
        begin
            // Random item. An insert that would land is turned around, or made a lookup where its
            // bounds are equal, so that the key space is not used up by chance.
            it.op = 1'($urandom_range(0, 1));
            if (it.op == OP_INSERT && (it.key_low & mask) <= (it.key_high & mask)
                    && {32'd0, it.key_low & mask} > last && table_used < TABLE_DEPTH)
            begin
                if ((it.key_low & mask) == (it.key_high & mask))
                    it.op = OP_LOOKUP;
                else
                begin
                    v           = it.key_low;
                    it.key_low  = it.key_high;
                    it.key_high = v;
                end
            end
        end
        return it;
    endfunction

    // Presents one item in the sender's burst pattern and records its expected result
    // once the block takes it.
    task automatic send_item(in_item_t it, logic typed, out_item_t want);
        out_item_t predicted;
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = step_interval_table(it);
        expected_results.push_back(typed ? want : predicted);
        n_items++;
        if (predicted.status == ST_ERR)
            n_errors++;
        else if (predicted.status == ST_MISS)
            n_misses++;
        else if (it.op == OP_INSERT)
            n_stored++;
        else
            n_hits++;
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_key_mode(logic [MODE_W-1:0] m);
        wait_idle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we   <= 1'b0;
        mode_now = m;
    endtask

    task automatic run_random(logic [MODE_W-1:0] m, int count, int insert_pct);
        if (m != mode_now)
            set_key_mode(m);
        repeat (count)
        begin
            if ($urandom_range(0, 49) == 0)
                wait_idle();
            send_item(make_random_item(insert_pct), UNTYPED, R_NONE);
        end
    endtask

    task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Each result strobe is matched against the oldest outstanding item.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: result with no item outstanding, status %0d index %0d",
                         $time, result.status, result.entry_index);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", KEY_W'(want.status), KEY_W'(result.status));
                check_field("entry_index", KEY_W'(want.entry_index), KEY_W'(result.entry_index));
                check_field("range_low", want.range_low, result.range_low);
                check_field("range_high", want.range_high, result.range_high);
                results_checked++;
            end
        end
    end

    // Ends a hung run: counts cycles in which neither an item nor a result moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: watchdog, nothing moved for %0d cycles", $time, quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int i;
        directed_rows = '{
            // Empty table: every lookup misses.
            {MODE_32, OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, TYPED, R_MISS},
            {MODE_32, OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED, R_MISS},
            // Reversed bounds, then the first intervals.
            {MODE_32, OP_INSERT, 32'd5, 32'd4, TYPED, R_ERR},
            {MODE_32, OP_INSERT, 32'd0, 32'd0, TYPED, R_OK},
            {MODE_32, OP_INSERT, 32'd0, 32'd10, TYPED, R_ERR},
            {MODE_32, OP_INSERT, 32'd1, 32'd100, TYPED, R_OK},
            {MODE_32, OP_INSERT, 32'd200, 32'd1000, TYPED, R_OK},
            // Hits on edges and inside, misses in gaps and past the end.
            {MODE_32, OP_LOOKUP, 32'd0, 32'd0, TYPED, R_OK},
            {MODE_32, OP_LOOKUP, 32'd150, 32'd0, TYPED, R_MISS},
            {MODE_32, OP_LOOKUP, 32'd500, 32'hFFFF_FFFF, TYPED, {ST_OK, 8'd2, 32'd200, 32'd1000}},
            {MODE_32, OP_LOOKUP, 32'd1001, 32'd0, TYPED, R_MISS},
            {MODE_32, OP_LOOKUP, 32'd100, 32'hFFFF_FFFF, TYPED, {ST_OK, 8'd1, 32'd1, 32'd100}},
            {MODE_32, OP_LOOKUP, 32'd1, 32'd0, UNTYPED, R_NONE},
            // Low bound equal to the previous high bound is refused.
            {MODE_32, OP_INSERT, 32'd1000, 32'd2000, TYPED, R_ERR},
            {MODE_32, OP_INSERT, 32'd1001, 32'd1001, TYPED, R_OK},
            {MODE_32, OP_LOOKUP, 32'd1001, 32'd0, UNTYPED, R_NONE},
            {MODE_32, OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, TYPED, R_ERR},
            // Sixteen-bit keys: upper halves are dropped on insert and on lookup.
            {MODE_16, OP_INSERT, 32'hABCD_1000, 32'h1234_2000, TYPED, R_OK},
            {MODE_16, OP_LOOKUP, 32'h5555_1800, 32'd0, TYPED, {ST_OK, 8'd4, 32'h1000, 32'h2000}},
            {MODE_16, OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, TYPED, R_MISS},
            {MODE_16, OP_INSERT, 32'h0000_0800, 32'h0000_0900, TYPED, R_ERR},
            // Illegal width modes refuse everything.
            {MODE_BAD_LO, OP_LOOKUP, 32'h0000_1800, 32'd0, TYPED, R_ERR},
            {MODE_BAD_HI, OP_INSERT, 32'h0000_3000, 32'h0000_4000, TYPED, R_ERR},
            // Back at 32 bits the sixteen-bit entry has zero upper halves.
            {MODE_32, OP_LOOKUP, 32'h0000_1800, 32'd0, TYPED, {ST_OK, 8'd4, 32'h1000, 32'h2000}},
            {MODE_32, OP_LOOKUP, 32'h5555_1800, 32'd0, TYPED, R_MISS}
        };
        table_used = 0;
        mode_now   = MODE_32;
        burst_left = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_N; i++)
        begin
            if (directed_rows[i].mode != mode_now)
                set_key_mode(directed_rows[i].mode);
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases across all width settings; the table keeps growing.
        run_random(MODE_BAD_LO, 20, 40);
        run_random(MODE_16, 110, 40);
        run_random(MODE_32, 120, 40);
        run_random(MODE_BAD_HI, 20, 40);
        run_random(MODE_16, 50, 15);

        // Fill the table to one free slot, then close it with an interval up to the
        // top key; the insert after that finds the table full.
        set_key_mode(MODE_32);
        while (table_used < TABLE_DEPTH - 1)
            send_item(make_random_item(90), UNTYPED, R_NONE);
        send_item({OP_INSERT, table_hi[table_used - 1] + 32'd1, 32'hFFFF_FFFF}, UNTYPED, R_NONE);
        send_item({OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, UNTYPED, R_NONE);
        run_random(MODE_32, 40, 20);
        run_random(MODE_16, 20, 20);

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        $display("Ran %0d items over all four width modes: %0d stored, %0d hits,",
                 n_items, n_stored, n_hits);
        $display("%0d misses, %0d errors; table ended with %0d of %0d intervals.",
                 n_misses, n_errors, table_used, TABLE_DEPTH);
        $display("%0d results checked, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/itl_pkg.sv
sv/itl_bound_ram.sv
sv/itl_search_ctrl.sv
sv/interval_table_lookup.sv
verif/tb_top.sv
